### design/utf8_decode_line_column_macros.svh
// Assertion macros for the UTF-8 line/column decoder.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef UTF8_DECODE_LINE_COLUMN_MACROS_SVH
`define UTF8_DECODE_LINE_COLUMN_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define UTF8DLC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf8 decoder: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define UTF8DLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf8 decoder: next-cycle check failed");
`else
`define UTF8DLC_ASSERT_NOW(label, ante, cons)
`define UTF8DLC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### design/utf8dlc_pkg.sv
// Shared types, constants and decode functions of the UTF-8 line/column decoder.
// Depends on nothing.
`default_nettype none

package utf8dlc_pkg;

    localparam int LINE_BITS_DEF   = 24;
    localparam int COLUMN_BITS_DEF = 16;

    localparam int CP_W   = 21;
    localparam int LINE_W = 24;
    localparam int COL_W  = 16;
    localparam int MAX_RESULTS = 3;

    localparam logic [CP_W-1:0] NEWLINE_CP = 21'd10;

    // Lead byte classification masks and patterns.
    localparam logic [7:0] ASCII_MASK  = 8'b1000_0000;
    localparam logic [7:0] LEAD2_MASK  = 8'b1110_0000;
    localparam logic [7:0] LEAD2_PAT   = 8'b1100_0000;
    localparam logic [7:0] LEAD3_MASK  = 8'b1111_0000;
    localparam logic [7:0] LEAD3_PAT   = 8'b1110_0000;
    localparam logic [7:0] LEAD4_MASK  = 8'b1111_1000;
    localparam logic [7:0] LEAD4_PAT   = 8'b1111_0000;
    // Payload masks.
    localparam logic [7:0] LEAD2_DATA  = 8'b0001_1111;
    localparam logic [7:0] CONT_DATA   = 8'b0011_1111;
    localparam logic [7:0] LEAD3_DATA  = 8'b0000_1111;
    localparam logic [7:0] LEAD4_DATA  = 8'b0000_0111;

    // Sequence length codes; zero marks an invalid lead byte.
    typedef logic [2:0] t_len;
    localparam t_len LEN_BAD = 3'd0;
    localparam t_len LEN_1   = 3'd1;
    localparam t_len LEN_2   = 3'd2;
    localparam t_len LEN_3   = 3'd3;
    localparam t_len LEN_4   = 3'd4;

    // Up to three decoded characters produced by one input beat.
    typedef struct packed {
        logic [1:0]                      count;
        logic                            final_flag;
        logic [MAX_RESULTS-1:0][CP_W-1:0] cp;
        logic [MAX_RESULTS-1:0]          bad;
    } t_group;

    function automatic t_len lead_length(input logic [7:0] b);
        t_len len;
        if ((b & ASCII_MASK) == 8'h00) begin
            len = LEN_1;
        end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
            len = LEN_2;
        end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
            len = LEN_3;
        end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
            len = LEN_4;
        end else begin
            len = LEN_BAD;
        end
        return len;
    endfunction

    function automatic logic [CP_W-1:0] seq_value(input logic [7:0] b0, input logic [7:0] b1,
                                                  input logic [7:0] b2, input logic [7:0] b3,
                                                  input t_len len);
        logic [7:0] l2;
        logic [7:0] l3;
        logic [7:0] l4;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic [CP_W-1:0] v;
        l2 = b0 & LEAD2_DATA;
        l3 = b0 & LEAD3_DATA;
        l4 = b0 & LEAD4_DATA;
        c1 = b1 & CONT_DATA;
        c2 = b2 & CONT_DATA;
        c3 = b3 & CONT_DATA;
        unique case (len)
            LEN_1:   v = {14'd0, b0[6:0]};
            LEN_2:   v = {10'd0, l2[4:0], c1[5:0]};
            LEN_3:   v = {5'd0, l3[3:0], c1[5:0], c2[5:0]};
            LEN_4:   v = {l4[2:0], c1[5:0], c2[5:0], c3[5:0]};
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/utf8dlc_if.sv
// Valid/ready channel interfaces for raw bytes in and decoded characters out.
// Depends on utf8dlc_pkg for field widths.
`default_nettype none

interface utf8dlc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8dlc_out_if;
    logic                          valid;
    logic                          ready;
    logic [utf8dlc_pkg::CP_W-1:0]  code_point;
    logic                          bad_sequence;
    logic [utf8dlc_pkg::LINE_W-1:0] line_number;
    logic [utf8dlc_pkg::COL_W-1:0] column_number;
    logic                          final_result;

    modport source (output valid, output code_point, output bad_sequence,
                    output line_number, output column_number, output final_result,
                    input ready);
    modport sink   (input valid, input code_point, input bad_sequence,
                    input line_number, input column_number, input final_result,
                    output ready);
endinterface

`default_nettype wire

### design/utf8dlc_decode.sv
// Sequence assembly: holds the partial-sequence buffer and turns one byte into a group of
// up to three decoded characters. Depends on utf8dlc_pkg.
`default_nettype none

module utf8dlc_decode (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_take,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_last_byte,
    output utf8dlc_pkg::t_group      o_group
);

    logic [2:0][7:0] r_pend;
    logic [2:0][7:0] n_pend;
    logic [1:0]      r_pend_cnt;
    logic [1:0]      n_pend_cnt;
    logic [1:0]      r_need_cnt;
    logic [1:0]      n_need_cnt;

    logic [3:0][7:0]       buf_b;
    logic [2:0]            num;
    utf8dlc_pkg::t_len     cur_len;
    utf8dlc_pkg::t_len     flen;
    logic [2:0]            nxt;
    logic [1:0]            cnt;
    utf8dlc_pkg::t_group   grp;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            buf_b[k] = (2'(k) < r_pend_cnt) ? r_pend[k] : i_data_byte;
        end
        buf_b[3] = i_data_byte;
        num = {1'b0, r_pend_cnt} + 3'd1;

        grp            = '0;
        grp.final_flag = i_last_byte;
        n_pend         = r_pend;
        n_pend_cnt     = r_pend_cnt;
        n_need_cnt     = r_need_cnt;
        nxt            = '0;
        cnt            = '0;
        flen           = utf8dlc_pkg::LEN_BAD;

        if (r_pend_cnt == 2'd0) begin
            cur_len = utf8dlc_pkg::lead_length(i_data_byte);
        end else begin
            cur_len = {1'b0, r_need_cnt} + 3'd1;
        end

        if (i_last_byte) begin
            // End of input: walk the buffer, re-reading bytes behind a failed lead.
            for (int p = 0; p < 4; p++) begin
                if ((3'(p) < num) && (3'(p) == nxt)) begin
                    flen = utf8dlc_pkg::lead_length(buf_b[2'(p)]);
                    if (cnt != 2'd3) begin
                        if ((flen == utf8dlc_pkg::LEN_BAD) ||
                            ({1'b0, 3'(p)} + {1'b0, flen} > {1'b0, num})) begin
                            grp.bad[cnt] = 1'b1;
                            grp.cp[cnt]  = '0;
                            nxt          = 3'(p) + 3'd1;
                        end else begin
                            grp.bad[cnt] = 1'b0;
                            grp.cp[cnt]  = utf8dlc_pkg::seq_value(buf_b[2'(p)],
                                               buf_b[2'(p + 1)], buf_b[2'(p + 2)],
                                               buf_b[2'(p + 3)], flen);
                            nxt          = 3'(p) + flen;
                        end
                        cnt = cnt + 2'd1;
                    end
                end
            end
            grp.count  = cnt;
            n_pend_cnt = '0;
            n_need_cnt = '0;
        end else if (cur_len == utf8dlc_pkg::LEN_BAD) begin
            grp.count  = 2'd1;
            grp.bad[0] = 1'b1;
            n_pend_cnt = '0;
            n_need_cnt = '0;
        end else if (num >= cur_len) begin
            grp.count  = 2'd1;
            grp.cp[0]  = utf8dlc_pkg::seq_value(buf_b[0], buf_b[1], buf_b[2], buf_b[3],
                                                cur_len);
            n_pend_cnt = '0;
            n_need_cnt = '0;
        end else begin
            // Sequence still open: park the byte behind the ones already held.
            n_pend[r_pend_cnt] = i_data_byte;
            n_pend_cnt         = num[1:0];
            n_need_cnt         = 2'(cur_len - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= '0;
            r_need_cnt <= '0;
        end else if (i_take) begin
            r_pend_cnt <= n_pend_cnt;
            r_need_cnt <= n_need_cnt;
        end
        if (i_take) begin
            r_pend <= n_pend;
        end
    end

    assign o_group = grp;

endmodule

`default_nettype wire

### design/utf8dlc_emit.sv
// Result serializer: holds one character group, hands out one character per beat and
// keeps the saturating line and column counters. Depends on utf8dlc_pkg.
`default_nettype none

module utf8dlc_emit #(
    parameter int LINE_BITS   = utf8dlc_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = utf8dlc_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_grp_valid,
    input  wire utf8dlc_pkg::t_group            i_grp,
    output logic                                o_grp_ready,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [utf8dlc_pkg::CP_W-1:0]        o_code_point,
    output logic                                o_bad_sequence,
    output logic [utf8dlc_pkg::LINE_W-1:0]      o_line_number,
    output logic [utf8dlc_pkg::COL_W-1:0]       o_column_number,
    output logic                                o_final_result
);

    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};

    utf8dlc_pkg::t_group r_grp;
    logic                r_grp_valid;
    logic [1:0]          r_idx;

    logic [LINE_BITS-1:0]   r_line;
    logic [LINE_BITS-1:0]   n_line;
    logic [COLUMN_BITS-1:0] r_col;
    logic [COLUMN_BITS-1:0] n_col;

    logic                         r_out_valid;
    logic [utf8dlc_pkg::CP_W-1:0] r_cp;
    logic                         r_bad;
    logic [LINE_BITS-1:0]         r_line_out;
    logic [COLUMN_BITS-1:0]       r_col_out;
    logic                         r_final;

    logic                         out_free;
    logic                         pop;
    logic                         last_entry;
    logic                         load;
    logic [utf8dlc_pkg::CP_W-1:0] sel_cp;
    logic                         sel_bad;
    logic [31:0]                  line_ext;
    logic [31:0]                  col_ext;

    assign out_free    = !r_out_valid || i_ready;
    assign pop         = r_grp_valid && out_free;
    assign last_entry  = (r_idx == (r_grp.count - 2'd1));
    assign o_grp_ready = !r_grp_valid || (pop && last_entry);
    assign load        = i_grp_valid && o_grp_ready;

    assign sel_cp  = r_grp.cp[r_idx];
    assign sel_bad = r_grp.bad[r_idx];

    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        if (!sel_bad && (sel_cp == utf8dlc_pkg::NEWLINE_CP)) begin
            if (r_line != LINE_MAX) begin
                n_line = r_line + LINE_BITS'(1);
            end
            n_col = '0;
        end else if (r_col != COL_MAX) begin
            n_col = r_col + COLUMN_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_line      <= '0;
            r_col       <= '0;
        end else begin
            if (load) begin
                r_grp_valid <= (i_grp.count != 2'd0);
                r_idx       <= '0;
            end else if (pop) begin
                r_grp_valid <= !last_entry;
                r_idx       <= r_idx + 2'd1;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
                r_line      <= n_line;
                r_col       <= n_col;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (load) begin
            r_grp <= i_grp;
        end
        if (pop) begin
            r_cp       <= sel_bad ? '0 : sel_cp;
            r_bad      <= sel_bad;
            r_line_out <= n_line;
            r_col_out  <= n_col;
            r_final    <= r_grp.final_flag && last_entry;
        end
    end

    assign line_ext = 32'(r_line_out);
    assign col_ext  = 32'(r_col_out);

    assign o_valid         = r_out_valid;
    assign o_code_point    = r_cp;
    assign o_bad_sequence  = r_bad;
    assign o_line_number   = line_ext[utf8dlc_pkg::LINE_W-1:0];
    assign o_column_number = col_ext[utf8dlc_pkg::COL_W-1:0];
    assign o_final_result  = r_final;

endmodule

`default_nettype wire

### design/utf8_decode_line_column.sv
// UTF-8 decoder with line and column tracking: input register, decoder and serializer.
// Depends on utf8dlc_pkg, utf8dlc_if, utf8dlc_decode, utf8dlc_emit and the macros header.
//
// Usage: raw bytes arrive on i_in, one per beat, with last_byte set on the final byte of
// an input. Each complete UTF-8 sequence (1 to 4 bytes, length set by its lead byte) gives
// one beat on o_out carrying the code point, an error flag, and the line and column after
// that character. A bad lead byte gives one error beat. On the final byte an unfinished
// sequence gives an error for its lead, and the bytes behind it are decoded again, so that
// byte may give up to three beats; final_result marks the last of them.
// Path: a byte passes the input register, the serializer's group register and the output
// register on its way to o_out. Throughput: one byte per cycle while each byte gives at
// most one result and o_out is ready. A final byte that gives k results keeps the
// serializer busy until all k are out, one per beat, and holds off the byte behind it.
// Stall: when o_out is not ready the output register holds its beat, the serializer holds
// its group, and i_in.ready drops once the input register also fills; nothing is lost.
// Reset (i_rst_n low, synchronous) empties all stages, drops the partial sequence and
// clears the line and column counters. The counters otherwise run across inputs and
// saturate at their full width.
`default_nettype none
`include "utf8_decode_line_column_macros.svh"

module utf8_decode_line_column #(
    parameter int LINE_BITS   = utf8dlc_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = utf8dlc_pkg::COLUMN_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    utf8dlc_in_if.sink    i_in,
    utf8dlc_out_if.source o_out
);

    // Input register stage.
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;

    logic                grp_ready;
    logic                take;
    logic                in_fire;
    utf8dlc_pkg::t_group group;

    // The byte moves on whenever the serializer can take its group.
    assign take       = r_s1_valid && grp_ready;
    assign i_in.ready = !r_s1_valid || take;
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (take) begin
            r_s1_valid <= 1'b0;
        end
        if (in_fire) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_last <= i_in.last_byte;
        end
    end

    // Decoder: partial-sequence buffer and per-byte character group.
    utf8dlc_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (r_s1_byte),
        .i_last_byte (r_s1_last),
        .o_group     (group)
    );

    // Serializer: one character per output beat, with position counters.
    utf8dlc_emit #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_grp_valid     (r_s1_valid),
        .i_grp           (group),
        .o_grp_ready     (grp_ready),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_code_point    (o_out.code_point),
        .o_bad_sequence  (o_out.bad_sequence),
        .o_line_number   (o_out.line_number),
        .o_column_number (o_out.column_number),
        .o_final_result  (o_out.final_result)
    );

    // An error character never carries a code point.
    `UTF8DLC_ASSERT_NOW(a_bad_has_zero_cp, o_out.valid && o_out.bad_sequence,
                        o_out.code_point == '0)
    // A good newline always leaves the column at zero.
    `UTF8DLC_ASSERT_NOW(a_newline_clears_col,
                        o_out.valid && !o_out.bad_sequence &&
                        (o_out.code_point == utf8dlc_pkg::NEWLINE_CP),
                        o_out.column_number == '0)
    // A byte held in the input register stays there until the serializer takes it.
    `UTF8DLC_ASSERT_NEXT(a_s1_holds, r_s1_valid && !take,
                         r_s1_valid && $stable(r_s1_byte) && $stable(r_s1_last))

endmodule

`default_nettype wire
